[src/lavm_pkg.sv]
// ----------------------------------------------------------------------------
// lavm_pkg: shared types for the look-at view matrix block
// Request and row types, the fixed-point limits and the normalize helpers.
// ----------------------------------------------------------------------------
package lavm_pkg;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } lavm_req_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               degenerate;
    logic               last_row;
  } lavm_row_t;

  localparam logic [63:0] DOT_LIMIT = 64'd4290672328;
  localparam logic [31:0] NEAR_Z    = 32'd65471;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // Magnitudes of a vector with its largest component moved to bit 29.
  typedef struct packed {
    logic [29:0] m0;
    logic [29:0] m1;
    logic [29:0] m2;
    logic [2:0]  neg;
    logic        zero;
  } lavm_scaled_t;

  function automatic logic [63:0] lavm_abs(input logic signed [63:0] v);
    lavm_abs = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic lavm_scaled_t lavm_scale(input logic signed [63:0] a,
                                              input logic signed [63:0] b,
                                              input logic signed [63:0] c);
    logic [63:0] ma, mb, mc, mx;
    logic [5:0]  p;
    lavm_scaled_t s;
    ma = lavm_abs(a);
    mb = lavm_abs(b);
    mc = lavm_abs(c);
    mx = ma | mb | mc;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (mx[i]) p = 6'(i);
    end
    s.zero = (mx == '0);
    s.neg = {c[63], b[63], a[63]};
    if (p > 6'd29) begin
      s.m0 = 30'(ma >> (p - 6'd29));
      s.m1 = 30'(mb >> (p - 6'd29));
      s.m2 = 30'(mc >> (p - 6'd29));
    end else begin
      s.m0 = 30'(ma << (6'd29 - p));
      s.m1 = 30'(mb << (6'd29 - p));
      s.m2 = 30'(mc << (6'd29 - p));
    end
    lavm_scale = s;
  endfunction

endpackage

[src/look_at_view_matrix_top.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix_top: look-at view matrix in signed Q16.16
// Builds the four rows of a view matrix from eye, target and up.
// ----------------------------------------------------------------------------
// Usage: a request (eye, target, up) enters on req_valid/req_ready. Four row
// results leave on row_valid/row_ready, rows 0 to 3, last_row on row 3.
// The datapath is one long pipeline: normalize forward and up, dot test and
// up replacement, cross and normalize for left, cross and normalize for
// true up, then translation products and their sum. Each normalizer takes
// its square root one bit a stage and divides one bit a stage. row_valid
// rises once a request has passed every stage into the output holder.
// Throughput is set by the output serializer, which sends each request as
// four rows; the pipeline advances only when its last stage can drain.
// A stalled receiver freezes the whole pipeline; nothing is lost.
// Reset clears all valid bits and the row counter; payloads are not reset.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  lavm_pkg::lavm_req_t  req,
  output logic                 row_valid,
  input  logic                 row_ready,
  output lavm_pkg::lavm_row_t  row
);
  import lavm_pkg::*;

  localparam int NormLat = 81;
  localparam int Lat = 3 * NormLat + 4 + 3;
  localparam int EyeF = 1 + NormLat + 2 + 1 + NormLat + 1 + NormLat;

  // Global advance: the pipeline moves when the holder is empty or drains.
  logic       hold_v;
  logic [1:0] cnt;
  logic       en;
  assign en = !hold_v || (row_ready && cnt == 2'd3);
  assign req_ready = en;

  logic vpipe [Lat+1];
  always_comb vpipe[0] = req_valid;
  for (genvar k = 0; k < Lat; k++) begin : g_v
    always_ff @(posedge clk) begin
      if (rst) vpipe[k+1] <= 1'b0;
      else if (en) vpipe[k+1] <= vpipe[k];
    end
  end

  // Eye travels alongside the datapath up to the translation products.
  logic signed [31:0] eye [3][EyeF+1];
  always_comb begin
    eye[0][0] = req.eye_x;
    eye[1][0] = req.eye_y;
    eye[2][0] = req.eye_z;
  end
  for (genvar k = 0; k < EyeF; k++) begin : g_eye
    always_ff @(posedge clk) begin
      if (en) for (int i = 0; i < 3; i++) eye[i][k+1] <= eye[i][k];
    end
  end

  // Stage A: forward difference.
  logic signed [63:0] fd [3];
  logic signed [31:0] ua [3];
  always_ff @(posedge clk) begin
    if (en) begin
      fd[0] <= 64'(req.target_x) - 64'(req.eye_x);
      fd[1] <= 64'(req.target_y) - 64'(req.eye_y);
      fd[2] <= 64'(req.target_z) - 64'(req.eye_z);
      ua[0] <= req.up_x;
      ua[1] <= req.up_y;
      ua[2] <= req.up_z;
    end
  end

  logic signed [31:0] f [3], u [3];
  logic fz, uz;
  lavm_norm u_nf (.clk, .rst, .en, .a(fd[0]), .b(fd[1]), .c(fd[2]),
                  .o0(f[0]), .o1(f[1]), .o2(f[2]), .zero(fz));
  lavm_norm u_nu (.clk, .rst, .en, .a(64'(ua[0])), .b(64'(ua[1])), .c(64'(ua[2])),
                  .o0(u[0]), .o1(u[1]), .o2(u[2]), .zero(uz));

  // Stage B: dot products, registered.
  logic signed [63:0] dp [3];
  logic signed [31:0] fb [3], ub [3];
  logic               degb;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp[i] <= 64'(f[i]) * 64'(u[i]);
        fb[i] <= f[i];
        ub[i] <= u[i];
      end
      degb <= fz || uz;
    end
  end

  // Stage C: sum, compare, replace up.
  logic signed [31:0] fc [3], uc [3];
  logic               degc;
  logic signed [63:0] dsum;
  logic [31:0]        fzab;
  always_comb begin
    dsum = dp[0] + dp[1] + dp[2];
    fzab = fb[2][31] ? 32'(-fb[2]) : 32'(fb[2]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fc   <= fb;
      degc <= degb;
      if (lavm_abs(dsum) > DOT_LIMIT) begin
        uc[0] <= (fzab < NEAR_Z) ? 32'sd0 : ONE_Q16;
        uc[1] <= 32'sd0;
        uc[2] <= (fzab < NEAR_Z) ? ONE_Q16 : 32'sd0;
      end else begin
        uc <= ub;
      end
    end
  end

  // Stage D: left cross products, registered.
  logic signed [63:0] cp [6];
  always_ff @(posedge clk) begin
    if (en) begin
      cp[0] <= 64'(fc[1]) * 64'(uc[2]);
      cp[1] <= 64'(fc[2]) * 64'(uc[1]);
      cp[2] <= 64'(fc[2]) * 64'(uc[0]);
      cp[3] <= 64'(fc[0]) * 64'(uc[2]);
      cp[4] <= 64'(fc[0]) * 64'(uc[1]);
      cp[5] <= 64'(fc[1]) * 64'(uc[0]);
    end
  end

  // Forward and degenerate delayed to meet left.
  localparam int FD = NormLat + 1;
  logic signed [31:0] fl [3][FD+1];
  logic               dl [FD+1];
  always_comb begin
    fl[0][0] = fc[0]; fl[1][0] = fc[1]; fl[2][0] = fc[2];
    dl[0] = degc;
  end
  for (genvar k = 0; k < FD; k++) begin : g_fl
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) fl[i][k+1] <= fl[i][k];
        dl[k+1] <= dl[k];
      end
    end
  end

  logic signed [31:0] lf [3];
  logic               lz;
  lavm_norm u_nl (.clk, .rst, .en, .a(cp[0] - cp[1]), .b(cp[2] - cp[3]),
                  .c(cp[4] - cp[5]), .o0(lf[0]), .o1(lf[1]), .o2(lf[2]), .zero(lz));

  // Stage E: true-up cross products.
  logic signed [63:0] tp [6];
  logic signed [31:0] le [3], fe [3];
  logic               de;
  always_ff @(posedge clk) begin
    if (en) begin
      tp[0] <= 64'(lf[1]) * 64'(fl[2][FD]);
      tp[1] <= 64'(lf[2]) * 64'(fl[1][FD]);
      tp[2] <= 64'(lf[2]) * 64'(fl[0][FD]);
      tp[3] <= 64'(lf[0]) * 64'(fl[2][FD]);
      tp[4] <= 64'(lf[0]) * 64'(fl[1][FD]);
      tp[5] <= 64'(lf[1]) * 64'(fl[0][FD]);
      le    <= lf;
      for (int i = 0; i < 3; i++) fe[i] <= fl[i][FD];
      de    <= dl[FD];
    end
  end

  localparam int TD = NormLat;
  logic signed [31:0] lt [3][TD+1], ft [3][TD+1];
  logic               dt [TD+1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lt[i][0] = le[i];
      ft[i][0] = fe[i];
    end
    dt[0] = de;
  end
  for (genvar k = 0; k < TD; k++) begin : g_tl
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          lt[i][k+1] <= lt[i][k];
          ft[i][k+1] <= ft[i][k];
        end
        dt[k+1] <= dt[k];
      end
    end
  end

  logic signed [31:0] tu [3];
  logic               tz;
  lavm_norm u_nt (.clk, .rst, .en, .a(tp[0] - tp[1]), .b(tp[2] - tp[3]),
                  .c(tp[4] - tp[5]), .o0(tu[0]), .o1(tu[1]), .o2(tu[2]), .zero(tz));

  // Stage F: translation products for the three rows.
  logic signed [31:0] rr [3][3];
  logic signed [63:0] tr [3][3];
  logic               dfg;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[0][i] = lt[i][TD];
      rr[1][i] = tu[i];
      rr[2][i] = -ft[i][TD];
    end
  end
  logic signed [31:0] rf [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++)
        for (int i = 0; i < 3; i++)
          tr[r][i] <= 64'(rr[r][i]) * 64'(eye[i][EyeF]);
      rf  <= rr;
      dfg <= dt[TD];
    end
  end

  // Stage G: sum, round, negate, saturate.
  logic signed [65:0] ts [3];
  logic signed [65:0] qn [3];
  logic signed [31:0] sat [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ts[r] = 66'(tr[r][0]) + 66'(tr[r][1]) + 66'(tr[r][2]) + 66'sd32768;
      qn[r] = -(ts[r] >>> 16);
      if (qn[r] > 66'sd2147483647) sat[r] = 32'h7fffffff;
      else if (qn[r] < -66'sd2147483648) sat[r] = 32'h80000000;
      else sat[r] = qn[r][31:0];
    end
  end

  logic signed [31:0] mat [3][4];
  logic               dg;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) mat[r][i] <= rf[r][i];
        mat[r][3] <= sat[r];
      end
      dg <= dfg;
    end
  end

  // Output holder: loads a finished matrix and serializes four rows.
  logic signed [31:0] hm [3][4];
  logic               hd;
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (en) begin
        hold_v <= vpipe[Lat];
        cnt    <= 2'd0;
      end else if (row_ready) begin
        cnt <= cnt + 2'd1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      hm <= mat;
      hd <= dg;
    end
  end

  always_comb begin
    row = '0;
    row.row_index  = cnt;
    row.degenerate = hd;
    row.last_row   = (cnt == 2'd3);
    if (!hd) begin
      if (cnt == 2'd3) begin
        row.col3 = ONE_Q16;
      end else begin
        row.col0 = hm[cnt][0];
        row.col1 = hm[cnt][1];
        row.col2 = hm[cnt][2];
        row.col3 = hm[cnt][3];
      end
    end
  end
  assign row_valid = hold_v;

  logic unused_lz, unused_tz;
  assign unused_lz = lz;
  assign unused_tz = tz;

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !hold_v |-> cnt == 2'd0) else $error("row counter moved while empty");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_ready |=> row_valid && $stable(cnt))
    else $error("row lost under stall");
  a_last: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_ready && row.last_row |-> req_ready)
    else $error("pipeline did not advance after last row");

endmodule

[src/lavm_norm.sv]
// ----------------------------------------------------------------------------
// lavm_norm: pipelined vector normalizer
// Scales a vector, then squares, square root (one bit per stage) and one
// restoring divider per component (one quotient bit per stage).
// A new vector may enter on every enabled cycle.
// ----------------------------------------------------------------------------
module lavm_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic signed [63:0] c,
  output logic signed [31:0] o0,
  output logic signed [31:0] o1,
  output logic signed [31:0] o2,
  output logic               zero
);
  import lavm_pkg::*;

  // Stages: scale, square-sum, 31 root steps, 48 divide steps.
  localparam int RootSteps = 31;
  localparam int DivSteps  = 48;

  lavm_scaled_t sc;
  logic [61:0]  sum;

  always_ff @(posedge clk) begin
    if (en) begin
      sc <= lavm_scale(a, b, c);
    end
  end

  lavm_scaled_t sq_s;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_s <= sc;
      sum  <= 62'({32'd0, sc.m0} * {32'd0, sc.m0}) + 62'({32'd0, sc.m1} * {32'd0, sc.m1})
            + 62'({32'd0, sc.m2} * {32'd0, sc.m2});
    end
  end

  // Restoring square root over RootSteps stages, one result bit per stage.
  logic [61:0]  rt_rem  [RootSteps+1];
  logic [30:0]  rt_root [RootSteps+1];
  lavm_scaled_t rt_s    [RootSteps+1];
  always_comb begin
    rt_rem[0]  = sum;
    rt_root[0] = '0;
    rt_s[0]    = sq_s;
  end

  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    localparam int Sh = 2 * (RootSteps - 1 - k);
    logic [63:0] trial;
    logic [63:0] rem_w;
    always_comb begin
      trial = ({33'd0, rt_root[k]} << (Sh + 2)) | (64'd1 << Sh);
      rem_w = {2'd0, rt_rem[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt_s[k+1] <= rt_s[k];
        if (rem_w >= trial) begin
          rt_rem[k+1]  <= 62'(rem_w - trial);
          rt_root[k+1] <= {rt_root[k][29:0], 1'b1};
        end else begin
          rt_rem[k+1]  <= rt_rem[k];
          rt_root[k+1] <= {rt_root[k][29:0], 1'b0};
        end
      end
    end
  end

  // Dividend m*65536 + len/2 for three components, divided by len.
  logic [47:0] dv_num [3][DivSteps+1];
  logic [30:0] dv_rem [3][DivSteps+1];
  logic [30:0] dv_len [DivSteps+1];
  logic [2:0]  dv_neg [DivSteps+1];
  logic        dv_zero[DivSteps+1];
  logic [29:0] mm [3];
  logic [30:0] len_w;
  always_comb begin
    len_w = rt_root[RootSteps];
    mm[0] = rt_s[RootSteps].m0;
    mm[1] = rt_s[RootSteps].m1;
    mm[2] = rt_s[RootSteps].m2;
    for (int i = 0; i < 3; i++) begin
      dv_num[i][0] = {mm[i], 16'd0} + 48'(len_w >> 1);
      dv_rem[i][0] = '0;
    end
    dv_len[0]  = len_w;
    dv_neg[0]  = rt_s[RootSteps].neg;
    dv_zero[0] = rt_s[RootSteps].zero;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dv_len[k+1]  <= dv_len[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_zero[k+1] <= dv_zero[k];
      end
    end
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [31:0] shr;
      always_comb shr = {dv_rem[i][k], dv_num[i][k][47]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (shr >= {1'b0, dv_len[k]} && dv_len[k] != '0) begin
            dv_rem[i][k+1] <= 31'(shr - {1'b0, dv_len[k]});
            dv_num[i][k+1] <= {dv_num[i][k][46:0], 1'b1};
          end else begin
            dv_rem[i][k+1] <= 31'(shr);
            dv_num[i][k+1] <= {dv_num[i][k][46:0], 1'b0};
          end
        end
      end
    end
  end

  logic [31:0] q [3];
  always_comb begin
    for (int i = 0; i < 3; i++) q[i] = dv_zero[DivSteps] ? '0 : dv_num[i][DivSteps][31:0];
    o0   = dv_neg[DivSteps][0] ? -$signed(q[0]) : $signed(q[0]);
    o1   = dv_neg[DivSteps][1] ? -$signed(q[1]) : $signed(q[1]);
    o2   = dv_neg[DivSteps][2] ? -$signed(q[2]) : $signed(q[2]);
    zero = dv_zero[DivSteps];
  end

  // rst is unused in the datapath; payload registers carry no reset.
  logic unused_rst;
  assign unused_rst = rst;

endmodule
